// ===== rtl/loop_pattern_sequencer_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef LOOP_PATTERN_SEQUENCER_MACROS_SVH
`define LOOP_PATTERN_SEQUENCER_MACROS_SVH

// Plain clocked property, disabled during reset.
`define LPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define LPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lps_pkg.sv =====
// Shared constants, codes and types of the loop pattern sequencer.
`timescale 1ns / 1ps
package lps_pkg;
	localparam int NUM_PATTERNS   = 8;
	localparam int MAX_EVENTS     = 32;
	localparam int PLAYLIST_DEPTH = 16;

	localparam int PAT_W    = 3;
	localparam int EV_IDX_W = $clog2(MAX_EVENTS);
	localparam int EV_CNT_W = $clog2(MAX_EVENTS + 1);
	localparam int EV_DEPTH = NUM_PATTERNS * MAX_EVENTS;
	localparam int EV_ADDR_W = $clog2(EV_DEPTH);
	localparam int PL_IDX_W = $clog2(PLAYLIST_DEPTH);
	localparam int PL_CNT_W = $clog2(PLAYLIST_DEPTH + 1);

	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 26;
	localparam int STEP_W  = 6;

	localparam logic [3:0] CMD_TICK      = 4'd0;
	localparam logic [3:0] CMD_PLAY      = 4'd1;
	localparam logic [3:0] CMD_STOP      = 4'd2;
	localparam logic [3:0] CMD_REC_START = 4'd3;
	localparam logic [3:0] CMD_REC_STOP  = 4'd4;
	localparam logic [3:0] CMD_NOTE_ON   = 4'd5;
	localparam logic [3:0] CMD_NOTE_OFF  = 4'd6;
	localparam logic [3:0] CMD_DRUM      = 4'd7;
	localparam logic [3:0] CMD_LIST_ADD  = 4'd8;
	localparam logic [3:0] CMD_LIST_CLR  = 4'd9;
	localparam logic [3:0] CMD_CLR_PAT   = 4'd10;
	localparam logic [3:0] CMD_CLR_TRACK = 4'd11;

	localparam logic [1:0] KIND_NOTE  = 2'd0;
	localparam logic [1:0] KIND_DRUM  = 2'd1;
	localparam logic [1:0] KIND_ALLOFF = 2'd2;
	localparam logic [1:0] KIND_CLICK = 2'd3;

	localparam logic [2:0] REG_LOOP_LEN  = 3'd0;
	localparam logic [2:0] REG_SPB       = 3'd1;
	localparam logic [2:0] REG_GRID      = 3'd2;
	localparam logic [2:0] REG_WRAP      = 3'd3;
	localparam logic [2:0] REG_ARRANGE   = 3'd4;
	localparam logic [2:0] REG_ACTIVE    = 3'd5;
	localparam logic [2:0] REG_METRO     = 3'd6;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
		logic [STEP_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quot;
		logic [DIV_D_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  trk;
		logic [31:0] val;
		logic        on;
		logic        acc;
	} res_t;

	typedef struct packed {
		logic [23:0] ts;
		logic [31:0] val;
		logic [3:0]  trk;
		logic        on;
		logic        drum;
	} event_t;

	localparam int EV_W = $bits(event_t);
endpackage

// ===== rtl/lps_ram.sv =====
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/lps_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lps_pkg::div_req_t req,
	output lps_pkg::div_rsp_t rsp
);
	logic [lps_pkg::DIV_N_W-1:0] acc_q;
	logic [lps_pkg::DIV_D_W-1:0] rem_q;
	logic [lps_pkg::DIV_D_W-1:0] dvs_q;
	logic [lps_pkg::STEP_W-1:0]  cnt_q;
	logic                        done_q;
	logic [lps_pkg::DIV_D_W:0]   partial;
	logic [lps_pkg::DIV_D_W+1:0] diff;
	logic                        ge;

	assign partial = {rem_q, acc_q[lps_pkg::DIV_N_W-1]};
	assign diff    = {1'b0, partial} - {2'b00, dvs_q};
	assign ge      = !diff[lps_pkg::DIV_D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == lps_pkg::STEP_W'(1));
			if (req.start) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[lps_pkg::DIV_N_W-2:0], ge};
			rem_q <= ge ? diff[lps_pkg::DIV_D_W-1:0] : partial[lps_pkg::DIV_D_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q;
	assign rsp.rem  = rem_q;
endmodule

// ===== rtl/loop_pattern_sequencer.sv =====
// Top level of the loop pattern sequencer: command sequencer and result buffering.
//
// Usage: commands enter on the in channel (in_valid/in_ready) with track,
// note_value and pattern_id; results leave on the out channel
// (out_valid/out_ready), the final result of a command marked by last.
// Registers are written on the cfg channel (cfg_index, cfg_data), always ready.
// One command is handled at a time; in_ready is high only while idle.
// Simple commands pass through the dispatch and finish states. A tick runs the beat
// divider when the metronome is on, then reads and checks each stored event of the
// played pattern while playing, then advances the position, with all-notes-off
// at loop end in arrange mode with a nonempty playlist. A recorded note with grid
// snapping takes a 26-step and a 48-step pass of the shared bit-serial divider plus a
// multiply. Clear track reads each stored event and rewrites the kept ones.
// Results are held in a one-entry buffer plus the output register; when the
// receiver stalls the sequencer waits and nothing is lost.
// Reset clears position, playlist, event counts and play/record state;
// register values return to their defaults. Event memory is not cleared.
`timescale 1ns / 1ps
module loop_pattern_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  command,
	input  logic [3:0]  track,
	input  logic [31:0] note_value,
	input  logic [2:0]  pattern_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  track_res,
	output logic [31:0] note_value_res,
	output logic        note_on,
	output logic        accented,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	`include "loop_pattern_sequencer_macros.svh"

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DISP    = 5'd1;
	localparam logic [4:0] S_TK_DIV  = 5'd2;
	localparam logic [4:0] S_TK_CLK  = 5'd3;
	localparam logic [4:0] S_TK_PLAY = 5'd4;
	localparam logic [4:0] S_SCAN_RD = 5'd5;
	localparam logic [4:0] S_SCAN_EV = 5'd6;
	localparam logic [4:0] S_TK_ADV  = 5'd7;
	localparam logic [4:0] S_AOFF    = 5'd8;
	localparam logic [4:0] S_SN_DIV1 = 5'd9;
	localparam logic [4:0] S_SN_MUL  = 5'd10;
	localparam logic [4:0] S_SN_GO2  = 5'd11;
	localparam logic [4:0] S_SN_DIV2 = 5'd12;
	localparam logic [4:0] S_REC     = 5'd13;
	localparam logic [4:0] S_CT_RD   = 5'd14;
	localparam logic [4:0] S_CT_EV   = 5'd15;
	localparam logic [4:0] S_FIN     = 5'd16;

	// configuration
	logic [23:0] loop_len_q, spb_q, grid_q, wrap_q;
	logic        arrange_q, metro_q;
	logic [2:0]  active_q;

	// sequencer state
	logic [4:0]  state_q;
	logic [3:0]  cmd_q, trk_q;
	logic [31:0] val_q;
	logic [2:0]  pid_q;
	logic [23:0] pos_q;
	logic        playing_q, recording_q;
	logic [lps_pkg::PL_IDX_W-1:0] pl_idx_q;
	logic [lps_pkg::PL_CNT_W-1:0] pl_cnt_q;
	logic [2:0]  pl_store_q [lps_pkg::PLAYLIST_DEPTH];
	logic [lps_pkg::EV_CNT_W-1:0] ev_cnt_q [lps_pkg::NUM_PATTERNS];
	logic [2:0]  pat_q;
	logic [lps_pkg::EV_CNT_W-1:0] idx_q, keep_q;
	logic [1:0]  aoff_q;
	logic [23:0] ts_q, n_q;
	logic [47:0] prod_q;

	// result buffering
	lps_pkg::res_t hold_q, out_q, push_res;
	logic          hold_v_q, out_v_q, out_last_q;
	logic          out_free, push_ok, push_en, fin_load;

	lps_pkg::div_req_t div_req;
	lps_pkg::div_rsp_t div_rsp;
	lps_pkg::event_t   ev_rd, ev_wr;
	logic [lps_pkg::EV_W-1:0] ram_rdata;
	logic [lps_pkg::EV_ADDR_W-1:0] ram_raddr, ram_waddr;
	logic          ram_we;

	logic [24:0] pos_next;
	logic [24:0] pos_wrap_sum;
	logic [lps_pkg::EV_CNT_W-1:0] cur_cnt, act_cnt;
	logic          ev_keep;
	logic [lps_pkg::PL_CNT_W-1:0] pl_idx_inc;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	assign out_free = !out_v_q || out_ready;
	assign push_ok  = !hold_v_q || out_free;
	assign fin_load = (state_q == S_FIN) && hold_v_q && out_free;

	assign pos_next     = {1'b0, pos_q} + 25'd1;
	assign pos_wrap_sum = {1'b0, pos_q} + {1'b0, wrap_q};
	assign cur_cnt      = ev_cnt_q[pat_q];
	assign act_cnt      = ev_cnt_q[active_q];
	assign pl_idx_inc   = {1'b0, pl_idx_q} + 1'b1;

	assign ram_raddr = {pat_q, idx_q[lps_pkg::EV_IDX_W-1:0]};
	assign ev_rd     = lps_pkg::event_t'(ram_rdata);
	assign ev_keep   = ev_rd.drum || (ev_rd.trk != trk_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {active_q, act_cnt[lps_pkg::EV_IDX_W-1:0]};
		ev_wr     = '0;
		if (state_q == S_REC) begin
			ram_we     = (act_cnt < lps_pkg::EV_CNT_W'(lps_pkg::MAX_EVENTS));
			ev_wr.ts   = ts_q;
			ev_wr.val  = val_q;
			ev_wr.trk  = (cmd_q == lps_pkg::CMD_DRUM) ? 4'd0 : trk_q;
			ev_wr.on   = (cmd_q != lps_pkg::CMD_NOTE_OFF);
			ev_wr.drum = (cmd_q == lps_pkg::CMD_DRUM);
		end else if (state_q == S_CT_EV) begin
			ram_we    = ev_keep;
			ram_waddr = {active_q, keep_q[lps_pkg::EV_IDX_W-1:0]};
			ev_wr     = ev_rd;
		end
	end

	always_comb begin
		push_en  = 1'b0;
		push_res = '0;
		case (state_q)
			S_TK_CLK: begin
				push_en       = push_ok && (div_rsp.rem == '0);
				push_res.kind = lps_pkg::KIND_CLICK;
				push_res.acc  = (div_rsp.quot[1:0] == 2'd0);
			end
			S_SCAN_EV: begin
				push_en       = push_ok && (ev_rd.ts == pos_q);
				push_res.kind = ev_rd.drum ? lps_pkg::KIND_DRUM : lps_pkg::KIND_NOTE;
				push_res.trk  = ev_rd.drum ? 4'd0 : ev_rd.trk;
				push_res.val  = ev_rd.val;
				push_res.on   = ev_rd.drum ? 1'b1 : ev_rd.on;
			end
			S_AOFF: begin
				push_en       = push_ok;
				push_res.kind = lps_pkg::KIND_ALLOFF;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		div_req       = '0;
		div_req.start = 1'b0;
		case (state_q)
			S_DISP: begin
				if (cmd_q == lps_pkg::CMD_TICK) begin
					div_req.start    = (playing_q || recording_q) && metro_q && (spb_q != '0);
					div_req.dividend = {pos_q, 24'd0};
					div_req.divisor  = {2'b00, spb_q};
					div_req.steps    = 6'd24;
				end else begin
					div_req.start    = recording_q && (grid_q != '0) &&
						(cmd_q == lps_pkg::CMD_NOTE_OFF ||
						 ((cmd_q == lps_pkg::CMD_NOTE_ON || cmd_q == lps_pkg::CMD_DRUM) &&
						  pos_wrap_sum <= {1'b0, loop_len_q}));
					div_req.dividend = {({1'b0, pos_q, 1'b0} + {2'b00, grid_q}), 22'd0};
					div_req.divisor  = {1'b0, grid_q, 1'b0};
					div_req.steps    = 6'd26;
				end
			end
			S_SN_GO2: begin
				div_req.start    = (loop_len_q != '0);
				div_req.dividend = prod_q;
				div_req.divisor  = {2'b00, loop_len_q};
				div_req.steps    = 6'd48;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_len_q <= 24'd96000;
			spb_q      <= 24'd24000;
			grid_q     <= 24'd0;
			wrap_q     <= 24'd2400;
			arrange_q  <= 1'b0;
			active_q   <= 3'd0;
			metro_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lps_pkg::REG_LOOP_LEN: loop_len_q <= cfg_data;
				lps_pkg::REG_SPB:      spb_q      <= cfg_data;
				lps_pkg::REG_GRID:     grid_q     <= cfg_data;
				lps_pkg::REG_WRAP:     wrap_q     <= cfg_data;
				lps_pkg::REG_ARRANGE:  arrange_q  <= cfg_data[0];
				lps_pkg::REG_ACTIVE:   active_q   <= cfg_data[2:0];
				lps_pkg::REG_METRO:    metro_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			playing_q   <= 1'b0;
			recording_q <= 1'b0;
			pl_idx_q    <= '0;
			pl_cnt_q    <= '0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			idx_q       <= '0;
			keep_q      <= '0;
			aoff_q      <= '0;
			for (int i = 0; i < lps_pkg::NUM_PATTERNS; i++) begin
				ev_cnt_q[i] <= '0;
			end
		end else begin
			if ((push_en && hold_v_q) || fin_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (push_en) begin
				hold_v_q <= 1'b1;
			end else if (fin_load) begin
				hold_v_q <= 1'b0;
			end
			if (state_q == S_REC && ram_we) begin
				ev_cnt_q[active_q] <= act_cnt + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (cmd_q)
						lps_pkg::CMD_TICK: begin
							if (!(playing_q || recording_q)) begin
								state_q <= S_FIN;
							end else begin
								state_q <= div_req.start ? S_TK_DIV : S_TK_PLAY;
							end
						end
						lps_pkg::CMD_PLAY: begin
							playing_q <= 1'b1;
							state_q   <= S_FIN;
						end
						lps_pkg::CMD_STOP: begin
							playing_q <= 1'b0;
							pos_q     <= '0;
							pl_idx_q  <= '0;
							aoff_q    <= '0;
							state_q   <= S_AOFF;
						end
						lps_pkg::CMD_REC_START: begin
							pos_q       <= '0;
							recording_q <= 1'b1;
							playing_q   <= 1'b1;
							aoff_q      <= '0;
							state_q     <= S_AOFF;
						end
						lps_pkg::CMD_REC_STOP: begin
							recording_q <= 1'b0;
							state_q     <= S_FIN;
						end
						lps_pkg::CMD_NOTE_ON, lps_pkg::CMD_DRUM, lps_pkg::CMD_NOTE_OFF: begin
							if (!recording_q) begin
								state_q <= S_FIN;
							end else if (div_req.start) begin
								state_q <= S_SN_DIV1;
							end else begin
								// wrapped note or no grid
								ts_q    <= (cmd_q != lps_pkg::CMD_NOTE_OFF &&
									pos_wrap_sum > {1'b0, loop_len_q}) ? 24'd0 : pos_q;
								state_q <= S_REC;
							end
						end
						lps_pkg::CMD_LIST_ADD: begin
							if (pl_cnt_q < lps_pkg::PL_CNT_W'(lps_pkg::PLAYLIST_DEPTH)) begin
								pl_cnt_q <= pl_cnt_q + 1'b1;
							end
							state_q <= S_FIN;
						end
						lps_pkg::CMD_LIST_CLR: begin
							pl_cnt_q <= '0;
							pl_idx_q <= '0;
							state_q  <= S_FIN;
						end
						lps_pkg::CMD_CLR_PAT: begin
							ev_cnt_q[active_q] <= '0;
							pos_q              <= '0;
							state_q            <= S_FIN;
						end
						lps_pkg::CMD_CLR_TRACK: begin
							pat_q   <= active_q;
							idx_q   <= '0;
							keep_q  <= '0;
							state_q <= S_CT_RD;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_TK_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_TK_CLK;
					end
				end
				S_TK_CLK: begin
					if (push_ok) begin
						state_q <= S_TK_PLAY;
					end
				end
				S_TK_PLAY: begin
					idx_q <= '0;
					if (playing_q && !arrange_q) begin
						pat_q   <= active_q;
						state_q <= S_SCAN_RD;
					end else if (playing_q && pl_cnt_q != '0 && {1'b0, pl_idx_q} < pl_cnt_q) begin
						pat_q   <= pl_store_q[pl_idx_q];
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_TK_ADV;
					end
				end
				S_SCAN_RD: begin
					state_q <= (idx_q < cur_cnt) ? S_SCAN_EV : S_TK_ADV;
				end
				S_SCAN_EV: begin
					if (push_ok || ev_rd.ts != pos_q) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_TK_ADV: begin
					if (pos_next >= {1'b0, loop_len_q}) begin
						pos_q <= '0;
						if (arrange_q && pl_cnt_q != '0) begin
							pl_idx_q <= (pl_idx_inc >= pl_cnt_q) ? '0
								: pl_idx_inc[lps_pkg::PL_IDX_W-1:0];
							aoff_q   <= '0;
							state_q  <= S_AOFF;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						pos_q   <= pos_next[23:0];
						state_q <= S_FIN;
					end
				end
				S_AOFF: begin
					if (push_ok) begin
						aoff_q <= aoff_q + 1'b1;
						if (aoff_q == 2'd3) begin
							state_q <= S_FIN;
						end
					end
				end
				S_SN_DIV1: begin
					if (div_rsp.done) begin
						n_q     <= div_rsp.quot[23:0];
						state_q <= S_SN_MUL;
					end
				end
				S_SN_MUL: begin
					state_q <= S_SN_GO2;
				end
				S_SN_GO2: begin
					if (div_req.start) begin
						state_q <= S_SN_DIV2;
					end else begin
						ts_q    <= '0;
						state_q <= S_REC;
					end
				end
				S_SN_DIV2: begin
					if (div_rsp.done) begin
						ts_q    <= div_rsp.rem[23:0];
						state_q <= S_REC;
					end
				end
				S_REC: begin
					state_q <= S_FIN;
				end
				S_CT_RD: begin
					if (idx_q < act_cnt) begin
						state_q <= S_CT_EV;
					end else begin
						ev_cnt_q[active_q] <= keep_q;
						state_q            <= S_FIN;
					end
				end
				S_CT_EV: begin
					if (ev_keep) begin
						keep_q <= keep_q + 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_CT_RD;
				end
				S_FIN: begin
					if (!hold_v_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= command;
			trk_q <= track;
			val_q <= note_value;
			pid_q <= pattern_id;
		end
		if (state_q == S_DISP && cmd_q == lps_pkg::CMD_LIST_ADD &&
			pl_cnt_q < lps_pkg::PL_CNT_W'(lps_pkg::PLAYLIST_DEPTH)) begin
			pl_store_q[pl_cnt_q[lps_pkg::PL_IDX_W-1:0]] <= pid_q;
		end
		if (state_q == S_SN_MUL) begin
			prod_q <= n_q * grid_q;
		end
		if (push_en) begin
			hold_q <= push_res;
			if (hold_v_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
		end
		if (fin_load) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid      = out_v_q;
	assign kind           = out_q.kind;
	assign track_res      = out_q.trk;
	assign note_value_res = out_q.val;
	assign note_on        = out_q.on;
	assign accented       = out_q.acc;
	assign last           = out_last_q;

	lps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lps_ram #(
		.WIDTH (lps_pkg::EV_W),
		.DEPTH (lps_pkg::EV_DEPTH)
	) u_ev_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ev_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`LPS_ASSERT_IMP(a_idle_hold_empty, in_ready, !hold_v_q, "result left in hold buffer at idle")
	`LPS_ASSERT_IMP(a_div_done_waited,
		div_rsp.done,
		state_q == S_TK_DIV || state_q == S_SN_DIV1 || state_q == S_SN_DIV2,
		"divider finished with no one waiting")
	`LPS_ASSERT(a_ev_cnt_bound,
		act_cnt <= lps_pkg::EV_CNT_W'(lps_pkg::MAX_EVENTS), "event count overflow")
	`LPS_ASSERT(a_pl_cnt_bound,
		pl_cnt_q <= lps_pkg::PL_CNT_W'(lps_pkg::PLAYLIST_DEPTH), "playlist overflow")
endmodule

// ===== bench/loop_pattern_sequencer_checker.sv =====
// Checker for the loop pattern sequencer: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
module loop_pattern_sequencer_checker
	import lps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  command,
	input  logic [3:0]  track,
	input  logic [31:0] note_value,
	input  logic [2:0]  pattern_id,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  track_res,
	input  logic [31:0] note_value_res,
	input  logic        note_on,
	input  logic        accented,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  trk;
		logic [31:0] val;
		logic        on;
		logic        acc;
		logic        last;
	} seq_beat_t;

	seq_beat_t expected_beats[$];
	seq_beat_t step_beats[$];

	logic [23:0] loop_len, beat_len, grid, wrap_thr;
	logic        arrange, metro;
	logic [2:0]  active;

	logic [23:0] pos;
	logic [3:0]  list_idx;
	logic [4:0]  list_cnt;
	logic [2:0]  list_pat[PLAYLIST_DEPTH];
	event_t      events[NUM_PATTERNS][MAX_EVENTS];
	logic [5:0]  ev_cnt[NUM_PATTERNS];
	logic        playing, recording;

	assign pending = expected_beats.size();

	task automatic emit(logic [1:0] k, logic [3:0] t, logic [31:0] v, logic o, logic a);
		seq_beat_t b;
		b = '{kind: k, trk: t, val: v, on: o, acc: a, last: 1'b0};
		step_beats = {step_beats, b};
	endtask

	task automatic emit_all_off();
		repeat (4) emit(KIND_ALLOFF, 4'd0, 32'd0, 1'b0, 1'b0);
	endtask

	function automatic logic [23:0] grid_time(logic [23:0] p);
		longint unsigned g, q;
		g = grid;
		if (g == 0)
			return p;
		if (loop_len == 0)
			return '0;
		q = ((2 * longint'(p) + g) / (2 * g)) * g;
		return 24'(q % loop_len);
	endfunction

	task automatic store_event(logic [23:0] ts, logic [31:0] v, logic [3:0] t, logic o,
			logic d);
		if (ev_cnt[active] >= MAX_EVENTS)
			return;
		events[active][ev_cnt[active]] = '{ts: ts, val: v, trk: d ? 4'd0 : t, on: o, drum: d};
		ev_cnt[active] = ev_cnt[active] + 1;
	endtask

	task automatic play_events(logic [2:0] p);
		for (int i = 0; i < ev_cnt[p]; i++) begin
			if (events[p][i].ts != pos)
				continue;
			if (events[p][i].drum)
				emit(KIND_DRUM, 4'd0, events[p][i].val, 1'b1, 1'b0);
			else
				emit(KIND_NOTE, events[p][i].trk, events[p][i].val, events[p][i].on, 1'b0);
		end
	endtask

	task automatic advance_tick();
		logic [31:0] nxt;
		longint unsigned bar;
		if (!playing && !recording)
			return;
		bar = longint'(beat_len) * 4;
		if (metro && beat_len != 0 && pos % beat_len == 0)
			emit(KIND_CLICK, 4'd0, 32'd0, 1'b0, (longint'(pos) % bar) == 0);
		if (playing) begin
			if (arrange) begin
				if (list_cnt > 0 && list_idx < list_cnt)
					play_events(list_pat[list_idx]);
			end else begin
				play_events(active);
			end
		end
		nxt = pos + 1;
		if (nxt >= loop_len) begin
			pos = '0;
			if (arrange && list_cnt > 0) begin
				list_idx = (list_idx + 1 >= list_cnt) ? 4'd0 : list_idx + 1;
				emit_all_off();
			end
		end else begin
			pos = nxt[23:0];
		end
	endtask

	task automatic sequence_step(logic [3:0] cmd, logic [3:0] t, logic [31:0] v,
			logic [2:0] pid);
		int k;
		logic [23:0] ts;
		step_beats.delete();
		case (cmd)
			CMD_TICK: advance_tick();
			CMD_PLAY: playing = 1'b1;
			CMD_STOP: begin
				playing = 1'b0;
				emit_all_off();
				pos = '0;
				list_idx = '0;
			end
			CMD_REC_START: begin
				emit_all_off();
				pos = '0;
				recording = 1'b1;
				playing = 1'b1;
			end
			CMD_REC_STOP: recording = 1'b0;
			CMD_NOTE_ON, CMD_DRUM: if (recording) begin
				if (25'(pos) + 25'(wrap_thr) > 25'(loop_len))
					ts = '0;
				else
					ts = grid_time(pos);
				store_event(ts, v, t, 1'b1, cmd == CMD_DRUM);
			end
			CMD_NOTE_OFF: if (recording)
				store_event(grid_time(pos), v, t, 1'b0, 1'b0);
			CMD_LIST_ADD: if (list_cnt < PLAYLIST_DEPTH) begin
				list_pat[list_cnt[3:0]] = pid;
				list_cnt = list_cnt + 1;
			end
			CMD_LIST_CLR: begin
				list_cnt = '0;
				list_idx = '0;
			end
			CMD_CLR_PAT: begin
				ev_cnt[active] = '0;
				pos = '0;
			end
			CMD_CLR_TRACK: begin
				k = 0;
				for (int i = 0; i < ev_cnt[active]; i++) begin
					if (!events[active][i].drum && events[active][i].trk == t)
						continue;
					events[active][k] = events[active][i];
					k++;
				end
				ev_cnt[active] = 6'(k);
			end
			default: ;
		endcase
		if (step_beats.size() > 0)
			step_beats[$].last = 1'b1;
		expected_beats = {expected_beats, step_beats};
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_len  = 24'd96000;
			beat_len  = 24'd24000;
			grid      = '0;
			wrap_thr  = 24'd2400;
			arrange   = 1'b0;
			active    = '0;
			metro     = 1'b0;
			pos       = '0;
			list_idx  = '0;
			list_cnt  = '0;
			playing   = 1'b0;
			recording = 1'b0;
			foreach (ev_cnt[i])
				ev_cnt[i] = '0;
			expected_beats.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOOP_LEN: loop_len = cfg_data;
					REG_SPB:      beat_len = cfg_data;
					REG_GRID:     grid = cfg_data;
					REG_WRAP:     wrap_thr = cfg_data;
					REG_ARRANGE:  arrange = cfg_data[0];
					REG_ACTIVE:   active = cfg_data[2:0];
					REG_METRO:    metro = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				sequence_step(command, track, note_value, pattern_id);
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat, kind %h value %h", $time, kind,
						note_value_res);
					errors++;
				end else begin
					seq_beat_t e;
					e = expected_beats.pop_front();
					check_field("kind", e.kind, kind);
					check_field("track", e.trk, track_res);
					check_field("note_value", e.val, note_value_res);
					check_field("note_on", e.on, note_on);
					check_field("accented", e.acc, accented);
					check_field("last", e.last, last);
				end
			end
		end
	end
endmodule

// ===== bench/loop_pattern_sequencer_tb.sv =====
// Testbench top for the loop pattern sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module loop_pattern_sequencer_tb;
	import lps_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  command = '0;
	logic [3:0]  track = '0;
	logic [31:0] note_value = '0;
	logic [2:0]  pattern_id = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  track_res;
	logic [31:0] note_value_res;
	logic        note_on, accented, last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	int          errors, pending;
	int          cycles = 0;
	int          stall_left = 0;
	logic        quiet = 1'b0;

	loop_pattern_sequencer dut (.*);
	loop_pattern_sequencer_checker checker_i (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			out_ready <= arst_n;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send(logic [3:0] cmd, logic [3:0] t, logic [31:0] v, logic [2:0] pid);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		command    <= cmd;
		track      <= t;
		note_value <= v;
		pattern_id <= pid;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_command(bit fill);
		int r;
		logic [3:0] cmd;
		r = $urandom_range(0, 99);
		if (r < 45)       cmd = CMD_TICK;
		else if (r < 60)  cmd = CMD_NOTE_ON;
		else if (r < 68)  cmd = CMD_NOTE_OFF;
		else if (r < 76)  cmd = CMD_DRUM;
		else if (r < 82)  cmd = CMD_LIST_ADD;
		else if (r < 84)  cmd = CMD_LIST_CLR;
		else if (r < 88)  cmd = fill ? CMD_NOTE_ON : CMD_CLR_TRACK;
		else if (r < 90)  cmd = fill ? CMD_DRUM : CMD_CLR_PAT;
		else if (r < 92)  cmd = CMD_PLAY;
		else if (r < 94)  cmd = CMD_STOP;
		else if (r < 96)  cmd = CMD_REC_START;
		else if (r < 98)  cmd = fill ? CMD_NOTE_OFF : CMD_REC_STOP;
		else              cmd = 4'($urandom_range(12, 15));
		send(cmd, 4'($urandom), $urandom, 3'($urandom));
	endtask

	task automatic run_phase(int len, int spb, int g, int wrap, int arr, int act, int met,
			int n, bit fill);
		cfg_write(REG_LOOP_LEN, 24'(len));
		cfg_write(REG_SPB, 24'(spb));
		cfg_write(REG_GRID, 24'(g));
		cfg_write(REG_WRAP, 24'(wrap));
		cfg_write(REG_ARRANGE, 24'(arr));
		cfg_write(REG_ACTIVE, 24'(act));
		cfg_write(REG_METRO, 24'(met));
		cfg_valid <= 1'b0;
		if (arr != 0) begin
			send(CMD_LIST_CLR, 4'($urandom), $urandom, 3'($urandom));
			repeat ($urandom_range(1, 5))
				send(CMD_LIST_ADD, 4'($urandom), $urandom, 3'($urandom));
		end
		send(CMD_REC_START, 4'($urandom), $urandom, 3'($urandom));
		repeat (n) random_command(fill);
		settle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle, ignored commands, record, wrap near loop end, playlist
		cfg_write(REG_LOOP_LEN, 24'd8);
		cfg_write(REG_SPB, 24'd2);
		cfg_write(REG_WRAP, 24'd2);
		cfg_write(REG_METRO, 24'd1);
		cfg_valid <= 1'b0;
		send(CMD_TICK, 4'd0, 32'd0, 3'd0);
		send(4'd12, 4'd15, 32'hFFFF_FFFF, 3'd7);
		send(4'd15, 4'd0, 32'd0, 3'd0);
		send(CMD_NOTE_ON, 4'd3, 32'h1234_5678, 3'd0);
		send(CMD_PLAY, 4'd0, 32'd0, 3'd0);
		send(CMD_TICK, 4'd0, 32'd0, 3'd0);
		send(CMD_STOP, 4'd0, 32'd0, 3'd0);
		send(CMD_REC_START, 4'd0, 32'd0, 3'd0);
		send(CMD_NOTE_ON, 4'd15, 32'hFFFF_FFFF, 3'd7);
		send(CMD_TICK, 4'd0, 32'd0, 3'd0);
		send(CMD_DRUM, 4'd15, 32'd0, 3'd0);
		send(CMD_TICK, 4'd0, 32'd0, 3'd0);
		send(CMD_NOTE_OFF, 4'd0, 32'h8000_0001, 3'd0);
		repeat (5) send(CMD_TICK, 4'd0, 32'd0, 3'd0);
		send(CMD_NOTE_ON, 4'd15, 32'h0000_00AA, 3'd0);
		repeat (3) send(CMD_TICK, 4'd0, 32'd0, 3'd0);
		send(CMD_CLR_TRACK, 4'd15, 32'd0, 3'd0);
		send(CMD_LIST_ADD, 4'd0, 32'd0, 3'd7);
		send(CMD_LIST_CLR, 4'd0, 32'd0, 3'd0);
		send(CMD_REC_STOP, 4'd0, 32'd0, 3'd0);
		send(CMD_CLR_PAT, 4'd0, 32'd0, 3'd0);
		settle();

		run_phase(1, 1, 0, 0, 0, 1, 1, 12, 1'b1);
		run_phase(12, 3, 4, 3, 1, 2, 1, 12, 1'b0);
		run_phase(16777215, 16777215, 16777215, 16777215, 0, 7, 1, 10, 1'b0);
		run_phase(10, 5, 3, 0, 1, 3, 0, 12, 1'b0);
		run_phase(6, 2, 0, 1, 0, 1, 1, 16, 1'b1);
		run_phase($urandom_range(2, 20), $urandom_range(1, 6), $urandom_range(0, 5),
			$urandom_range(0, 4), $urandom_range(0, 1), $urandom_range(0, 7), 1, 10, 1'b0);
		quiet <= 1'b1;
		run_phase($urandom_range(2, 20), $urandom_range(1, 6), $urandom_range(0, 5),
			$urandom_range(0, 4), 1, $urandom_range(0, 7), 1, 10, 1'b0);

		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_ram.sv
rtl/lps_div.sv
rtl/loop_pattern_sequencer.sv
bench/loop_pattern_sequencer_checker.sv
bench/loop_pattern_sequencer_tb.sv
